/* rtl/core/ple_pkg.sv */
// Package for the positional list engine: command and status codes, cell
// operation codes, field widths and the request bundle of the remainder unit.
// Depends on nothing; every other file of the block imports it.
package ple_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int WORD_W       = 32;
    localparam int POS_W        = 6;
    localparam int CMD_W        = 3;
    localparam int STAT_W       = 2;

    // Commands carried on the input beat.
    typedef enum logic [CMD_W-1:0] {
        CMD_APPEND     = 3'd0,
        CMD_INSERT_AT  = 3'd1,
        CMD_REMOVE_AT  = 3'd2,
        CMD_REMOVE_VAL = 3'd3,
        CMD_READ_AT    = 3'd4,
        CMD_SORT       = 3'd5
    } t_cmd;

    // Status codes returned with each result beat.
    typedef enum logic [STAT_W-1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } t_status;

    // What one list cell loads at the next edge.
    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_LEFT,
        CELL_RIGHT,
        CELL_LOW,
        CELL_HIGH
    } t_cell_op;

    // Controller states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_MOD,
        S_SCAN,
        S_SORT,
        S_EXEC
    } t_state;

    // Start request to the remainder unit.
    typedef struct packed {
        logic             start;
        logic [POS_W-1:0] dividend;
    } t_mod_req;

endpackage

/* rtl/core/positional_list_engine.sv */
// Top level of the positional list engine: controller, chain of list cells,
// remainder unit and the registered result beat.
// Depends on ple_pkg, ple_cell and ple_mod.
//
//  channel  | direction | tdata (low bit up)                        | tuser
//  ---------+-----------+-------------------------------------------+--------
//  s_axis   | in        | position[5:0], data_word[31:0], zero pad  | command
//  m_axis   | out       | status, result_word, entry_count, is_empty| -
//
// Append, read, remove at a non-negative position and unused codes go from
// accept straight to the final step and then to the result register. A negative
// position first passes through the bit-serial remainder unit. Remove by value
// scans one cell per cycle; sort runs count odd-even passes over the cell chain.
// Reset is synchronous, active low, and empties the list at once.
// One command is in work at a time; a result waits in the output register
// while the next command is accepted, and a stalled output holds the final step.
module positional_list_engine
    import ple_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // position, data_word, zero pad
    input  logic [39:0]          s_axis_tdata,
    // command
    input  logic [CMD_W-1:0]     s_axis_tuser,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // status, result_word, entry_count, is_empty, zero pad
    output logic [((STAT_W+WORD_W+$clog2(CAPACITY+1)+1+7)/8)*8-1:0] m_axis_tdata
);

    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int IDX_W  = $clog2(CAPACITY);
    localparam int OUT_W  = STAT_W + WORD_W + CNT_W + 1;
    localparam int OUT_TW = ((OUT_W + 7) / 8) * 8;
    localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

    t_state                   r_state;
    t_state                   n_state;
    t_cmd                     r_cmd;
    logic [POS_W-1:0]         r_mag;
    logic                     r_neg;
    logic signed [WORD_W-1:0] r_word;
    logic [CNT_W-1:0]         r_cnt;
    logic [CNT_W-1:0]         n_cnt;
    logic [CNT_W-1:0]         r_k;
    logic                     r_found;
    logic                     r_ov;
    logic [OUT_TW-1:0]        r_out_td;

    logic [POS_W-1:0]         w_in_pos;
    t_cmd                     w_in_cmd;
    logic                     w_in_neg;
    logic [POS_W-1:0]         w_in_mag;
    logic                     w_accept;
    logic                     w_need_mod;
    logic                     w_commit;
    logic                     w_full;
    logic                     w_empty;
    logic                     w_use_rem;
    logic                     w_past_end;
    logic [CNT_W-1:0]         w_idx;
    logic [IDX_W-1:0]         w_rd_addr;
    logic signed [WORD_W-1:0] w_rd_data;
    logic                     w_match;
    logic                     w_scan_end;
    t_status                  w_status;
    logic signed [WORD_W-1:0] w_result;
    t_mod_req                 w_mod_req;
    logic                     w_mod_done;
    logic [CNT_W-1:0]         w_rem;

    logic signed [WORD_W-1:0] w_val [CAPACITY];
    t_cell_op                 w_op  [CAPACITY];

    // Input beat decode and position magnitude.
    assign w_in_pos   = s_axis_tdata[POS_W-1:0];
    assign w_in_cmd   = t_cmd'(s_axis_tuser);
    assign w_in_neg   = w_in_pos[POS_W-1];
    assign w_in_mag   = w_in_neg ? (~w_in_pos + POS_W'(1)) : w_in_pos;
    assign w_accept   = s_axis_tvalid && s_axis_tready;
    assign w_need_mod = w_in_neg && (r_cnt != '0) &&
                        ((w_in_cmd == CMD_INSERT_AT) || (w_in_cmd == CMD_REMOVE_AT) ||
                         (w_in_cmd == CMD_READ_AT));

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_commit      = (r_state == S_EXEC) && (!r_ov || m_axis_tready);
    assign w_full        = (r_cnt == CNT_W'(CAPACITY));
    assign w_empty       = (r_cnt == '0);

    // Resolved index for the final step.
    assign w_use_rem  = r_neg && !w_empty;
    assign w_past_end = (CMP_W'(r_mag) >= CMP_W'(r_cnt));
    always_comb begin
        case (r_cmd)
            CMD_APPEND: w_idx = r_cnt;
            CMD_INSERT_AT: begin
                if (w_use_rem) w_idx = w_rem;
                else if (w_past_end) w_idx = r_cnt;
                else w_idx = CNT_W'(r_mag);
            end
            CMD_REMOVE_VAL: w_idx = r_k;
            default: begin
                if (w_use_rem) w_idx = w_rem;
                else if (w_past_end) w_idx = r_cnt - CNT_W'(1);
                else w_idx = CNT_W'(r_mag);
            end
        endcase
    end

    // Single read port over the cell row.
    assign w_rd_addr  = (r_state == S_SCAN) ? r_k[IDX_W-1:0] : w_idx[IDX_W-1:0];
    assign w_rd_data  = w_val[w_rd_addr];
    assign w_match    = (w_rd_data == r_word);
    assign w_scan_end = (r_k >= r_cnt);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (w_need_mod) n_state = S_MOD;
                    else if (w_in_cmd == CMD_REMOVE_VAL) n_state = S_SCAN;
                    else if ((w_in_cmd == CMD_SORT) && (r_cnt > CNT_W'(1))) n_state = S_SORT;
                    else n_state = S_EXEC;
                end
            end
            S_MOD:  if (w_mod_done) n_state = S_EXEC;
            S_SCAN: if (w_scan_end || w_match) n_state = S_EXEC;
            S_SORT: if (r_k == r_cnt - CNT_W'(1)) n_state = S_EXEC;
            S_EXEC: if (w_commit) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs of the final step: status, returned word and new count.
    always_comb begin
        w_status  = ST_OK;
        w_result  = '0;
        n_cnt     = r_cnt;
        w_mod_req = '{start: w_accept && w_need_mod, dividend: w_in_mag};
        case (r_cmd)
            CMD_APPEND, CMD_INSERT_AT: begin
                if (w_full) w_status = ST_FULL;
                else n_cnt = r_cnt + CNT_W'(1);
            end
            CMD_REMOVE_AT: begin
                if (w_empty) begin
                    w_status = ST_MISS;
                end else begin
                    w_result = w_rd_data;
                    n_cnt    = r_cnt - CNT_W'(1);
                end
            end
            CMD_REMOVE_VAL: begin
                if (r_found) begin
                    w_result = w_rd_data;
                    n_cnt    = r_cnt - CNT_W'(1);
                end else begin
                    w_status = ST_MISS;
                end
            end
            CMD_READ_AT: begin
                if (w_empty) w_status = ST_MISS;
                else w_result = w_rd_data;
            end
            CMD_SORT: begin
                if (w_empty) w_status = ST_MISS;
            end
            default: w_status = ST_OK;
        endcase
    end

    // Chain of list cells with their per-cell operation.
    for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
        logic signed [WORD_W-1:0] w_left;
        logic signed [WORD_W-1:0] w_right;

        if (gi == 0) begin : g_head
            assign w_left = '0;
        end else begin : g_mid_l
            assign w_left = w_val[gi-1];
        end
        if (gi == CAPACITY - 1) begin : g_tail
            assign w_right = '0;
        end else begin : g_mid_r
            assign w_right = w_val[gi+1];
        end

        // Sort passes pair cells by the pass parity; the final step shifts.
        always_comb begin
            w_op[gi] = CELL_HOLD;
            if (r_state == S_SORT) begin
                if ((1'(gi % 2) == r_k[0]) && (CNT_W'(gi + 1) < r_cnt)) begin
                    w_op[gi] = CELL_LOW;
                end else if ((gi > 0) && (1'((gi + 1) % 2) == r_k[0]) &&
                             (CNT_W'(gi) < r_cnt)) begin
                    w_op[gi] = CELL_HIGH;
                end
            end else if (w_commit) begin
                case (r_cmd)
                    CMD_APPEND, CMD_INSERT_AT: begin
                        if (!w_full) begin
                            if (CNT_W'(gi) == w_idx) w_op[gi] = CELL_LOAD;
                            else if (CNT_W'(gi) > w_idx) w_op[gi] = CELL_LEFT;
                        end
                    end
                    CMD_REMOVE_AT: begin
                        if (!w_empty && (CNT_W'(gi) >= w_idx)) w_op[gi] = CELL_RIGHT;
                    end
                    CMD_REMOVE_VAL: begin
                        if (r_found && (CNT_W'(gi) >= w_idx)) w_op[gi] = CELL_RIGHT;
                    end
                    default: w_op[gi] = CELL_HOLD;
                endcase
            end
        end

        ple_cell u_cell (
            .i_clk   (i_clk),
            .i_op    (w_op[gi]),
            .i_word  (r_word),
            .i_left  (w_left),
            .i_right (w_right),
            .o_value (w_val[gi])
        );
    end

    // Remainder unit for negative positions.
    ple_mod #(
        .CAPACITY (CAPACITY)
    ) u_mod (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (w_mod_req),
        .i_divisor (r_cnt),
        .o_done    (w_mod_done),
        .o_rem     (w_rem)
    );

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_commit) begin
                r_cnt <= n_cnt;
                r_ov  <= 1'b1;
            end else if (m_axis_tready) begin
                r_ov  <= 1'b0;
            end
        end
    end

    // Command registers, scan and pass counter, result beat.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd   <= w_in_cmd;
            r_mag   <= w_in_mag;
            r_neg   <= w_in_neg;
            r_word  <= $signed(s_axis_tdata[POS_W+WORD_W-1:POS_W]);
            r_k     <= '0;
            r_found <= 1'b0;
        end else if (r_state == S_SCAN) begin
            if (!w_scan_end && w_match) r_found <= 1'b1;
            else if (!w_scan_end) r_k <= r_k + CNT_W'(1);
        end else if (r_state == S_SORT) begin
            r_k <= r_k + CNT_W'(1);
        end
        if (w_commit) begin
            r_out_td <= OUT_TW'({(n_cnt == '0), n_cnt, w_result, w_status});
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = r_out_td;

    // The count never passes the capacity.
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    // A full status is only reported with a full list.
    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tdata[STAT_W-1:0] == ST_FULL)) |->
        (m_axis_tdata[STAT_W+WORD_W+CNT_W-1:STAT_W+WORD_W] == CNT_W'(CAPACITY)))
        else $error("full status with free slots");

    // The remainder unit finishes only while the controller waits for it.
    a_mod_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mod_done |-> (r_state == S_MOD))
        else $error("remainder done outside its wait state");

    // A committed step always leaves a result beat pending.
    a_commit_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_commit |=> (m_axis_tvalid && (r_state == S_IDLE)))
        else $error("final step without result beat");

endmodule

/* rtl/core/ple_cell.sv */
// One slot of the list chain: holds a word and loads from the input word,
// from either neighbor, or keeps the smaller or larger of a neighbor pair.
// Depends on ple_pkg.
module ple_cell
    import ple_pkg::*;
(
    input  logic                     i_clk,
    input  t_cell_op                 i_op,
    input  logic signed [WORD_W-1:0] i_word,
    input  logic signed [WORD_W-1:0] i_left,
    input  logic signed [WORD_W-1:0] i_right,
    output logic signed [WORD_W-1:0] o_value
);

    logic signed [WORD_W-1:0] r_value;
    logic signed [WORD_W-1:0] n_value;

    // Next value of the slot; the sort steps compare with one neighbor.
    always_comb begin
        n_value = r_value;
        case (i_op)
            CELL_LOAD:  n_value = i_word;
            CELL_LEFT:  n_value = i_left;
            CELL_RIGHT: n_value = i_right;
            CELL_LOW:   if (i_right < r_value) n_value = i_right;
            CELL_HIGH:  if (r_value < i_left)  n_value = i_left;
            default:    n_value = r_value;
        endcase
    end

    // Slot storage; contents are undefined until written.
    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;

endmodule

/* rtl/core/ple_mod.sv */
// Bit-serial remainder unit: six restoring steps of a position magnitude
// divided by the current entry count, one dividend bit per cycle.
// Depends on ple_pkg.
module ple_mod
    import ple_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  t_mod_req                         i_req,
    input  logic [$clog2(CAPACITY+1)-1:0]    i_divisor,
    output logic                             o_done,
    output logic [$clog2(CAPACITY+1)-1:0]    o_rem
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int BIT_W = $clog2(POS_W);

    logic [POS_W-1:0] r_dvd;
    logic [CNT_W-1:0] r_rem;
    logic [BIT_W-1:0] r_bit;
    logic             r_busy;
    logic             r_done;
    logic [CNT_W:0]   w_trial;
    logic [CNT_W:0]   w_step;

    // One restoring step: shift in the next dividend bit, subtract if it fits.
    always_comb begin
        w_trial = {r_rem, r_dvd[r_bit]};
        if (w_trial >= {1'b0, i_divisor}) begin
            w_step = w_trial - {1'b0, i_divisor};
        end else begin
            w_step = w_trial;
        end
    end

    // Control of the step sequence.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_bit == '0)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // Datapath of the step sequence.
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_dvd <= i_req.dividend;
            r_rem <= '0;
            r_bit <= BIT_W'(POS_W - 1);
        end else if (r_busy) begin
            r_rem <= w_step[CNT_W-1:0];
            r_bit <= r_bit - BIT_W'(1);
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

/* test/positional_list_engine_tb.sv */
// Self-checking testbench for the positional list engine: a list predictor in the
// bench computes each result beat, and a checker compares it with the block's output.
// Depends on ple_pkg and positional_list_engine.
`timescale 1ns / 100ps

module positional_list_engine_tb;
    import ple_pkg::*;

    localparam int LIST_CAP = CAPACITY_DEF;
    localparam int CNT_W    = $clog2(LIST_CAP + 1);
    localparam int OUT_W    = ((STAT_W + WORD_W + CNT_W + 1 + 7) / 8) * 8;

    // Command codes that the block must ignore.
    localparam logic [CMD_W-1:0] CMD_SPARE_A = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_B = 3'd7;

    // One result beat as the list predictor sees it.
    typedef struct packed {
        t_status           status;
        logic [WORD_W-1:0] word;
        logic [CNT_W-1:0]  count;
        logic              empty;
    } list_result_t;

    logic              i_clk;
    logic              i_rst_n;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [39:0]       s_axis_tdata;
    logic [CMD_W-1:0]  s_axis_tuser;
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [OUT_W-1:0]  m_axis_tdata;

    // Predicted list contents and the results still owed by the block.
    logic signed [WORD_W-1:0] model_words [LIST_CAP];
    int                       model_count;
    list_result_t             pending_results [$];

    int err_count;
    int send_idle_pct;
    int recv_stall_pct;
    bit hold_req;
    bit hold_used;
    int hold_left;

    positional_list_engine i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Clock with a 4 ns period.
    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // Run limit, far beyond the slowest legal run.
    initial begin
        #4_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Read and remove positions: past the end clamps to the tail, negative wraps.
    function automatic int resolve_pos(int p);
        if (p < 0) begin
            return (-p) % model_count;
        end
        return (p >= model_count) ? model_count - 1 : p;
    endfunction

    // Take one entry out of the predicted list and close the gap.
    function automatic logic [WORD_W-1:0] drop_entry(int idx);
        logic [WORD_W-1:0] v;
        v = model_words[idx];
        for (int i = idx; i + 1 < model_count; i++) begin
            model_words[i] = model_words[i + 1];
        end
        model_count--;
        return v;
    endfunction

    // Apply one command to the predicted list and return the result it gives.
    function automatic list_result_t apply_list_cmd(logic [CMD_W-1:0] cmd,
                                                    logic signed [POS_W-1:0] pos,
                                                    logic signed [WORD_W-1:0] word);
        list_result_t             r;
        int                       p;
        int                       idx;
        logic signed [WORD_W-1:0] t;
        r.status = ST_OK;
        r.word   = '0;
        p        = pos;
        case (cmd)
            CMD_APPEND: begin
                if (model_count >= LIST_CAP) begin
                    r.status = ST_FULL;
                end else begin
                    model_words[model_count] = word;
                    model_count++;
                end
            end
            CMD_INSERT_AT: begin
                if (model_count >= LIST_CAP) begin
                    r.status = ST_FULL;
                end else begin
                    // Insert past the end appends; a negative position wraps.
                    if (model_count == 0) begin
                        idx = 0;
                    end else if (p < 0) begin
                        idx = (-p) % model_count;
                    end else begin
                        idx = (p >= model_count) ? model_count : p;
                    end
                    for (int i = model_count; i > idx; i--) begin
                        model_words[i] = model_words[i - 1];
                    end
                    model_words[idx] = word;
                    model_count++;
                end
            end
            CMD_REMOVE_AT: begin
                if (model_count == 0) begin
                    r.status = ST_MISS;
                end else begin
                    r.word = drop_entry(resolve_pos(p));
                end
            end
            CMD_REMOVE_VAL: begin
                r.status = ST_MISS;
                for (int i = 0; i < model_count; i++) begin
                    if (model_words[i] == word) begin
                        r.word   = drop_entry(i);
                        r.status = ST_OK;
                        break;
                    end
                end
            end
            CMD_READ_AT: begin
                if (model_count == 0) begin
                    r.status = ST_MISS;
                end else begin
                    r.word = model_words[resolve_pos(p)];
                end
            end
            CMD_SORT: begin
                if (model_count == 0) begin
                    r.status = ST_MISS;
                end else begin
                    // Signed ascending order; equal words are indistinguishable.
                    for (int i = 0; i + 1 < model_count; i++) begin
                        for (int j = 0; j + 1 < model_count - i; j++) begin
                            if (model_words[j + 1] < model_words[j]) begin
                                t                  = model_words[j];
                                model_words[j]     = model_words[j + 1];
                                model_words[j + 1] = t;
                            end
                        end
                    end
                end
            end
            default: begin
            end
        endcase
        r.count = CNT_W'(model_count);
        r.empty = (model_count == 0);
        return r;
    endfunction

    // Offer one beat, wait until it is taken, then record its predicted result.
    task automatic send_item(input logic [CMD_W-1:0] cmd,
                             input logic signed [POS_W-1:0] pos,
                             input logic signed [WORD_W-1:0] word);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, word, pos};
        s_axis_tuser  <= cmd;
        @(posedge i_clk);
        while (!s_axis_tready) begin
            @(posedge i_clk);
        end
        pending_results.push_back(apply_list_cmd(cmd, pos, word));
    endtask

    // A data word: extremes, small values that repeat, list members or anything.
    function automatic logic [WORD_W-1:0] pick_word();
        case ($urandom_range(0, 9))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return '0;
            3: return '1;
            4, 5: return WORD_W'(int'($urandom_range(0, 20)) - 10);
            6, 7: begin
                if (model_count > 0) begin
                    return model_words[$urandom_range(0, model_count - 1)];
                end
                return $urandom;
            end
            default: return $urandom;
        endcase
    endfunction

    // Receiver: random stalls, plus one long hold-off counted here once requested.
    always @(posedge i_clk) begin
        if (hold_req && !hold_used) begin
            hold_left = 300;
            hold_used = 1'b1;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Checker: every result beat against the oldest prediction.
    always @(posedge i_clk) begin
        list_result_t got;
        list_result_t want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.status = t_status'(m_axis_tdata[STAT_W-1:0]);
            got.word   = m_axis_tdata[STAT_W+WORD_W-1:STAT_W];
            got.count  = m_axis_tdata[STAT_W+WORD_W+CNT_W-1:STAT_W+WORD_W];
            got.empty  = m_axis_tdata[STAT_W+WORD_W+CNT_W];
            if (pending_results.size() == 0) begin
                err_count++;
                $display("%0t: result beat with nothing outstanding: status %0d word %h count %0d",
                         $time, got.status, got.word, got.count);
            end else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    err_count++;
                    $display("%0t: mismatch: expected status %0d word %h count %0d empty %0b",
                             $time, want.status, want.word, want.count, want.empty);
                    $display("%0t:           actual status %0d word %h count %0d empty %0b",
                             $time, got.status, got.word, got.count, got.empty);
                end
            end
        end
    end

    // Every command that needs an entry, and the spare codes, on an empty list.
    task automatic test_empty_list();
        send_item(CMD_READ_AT, 6'sd0, 32'sd0);
        send_item(CMD_REMOVE_AT, -6'sd3, 32'sd0);
        send_item(CMD_REMOVE_VAL, 6'sd0, 32'sd0);
        send_item(CMD_SORT, 6'sd0, 32'sd0);
        send_item(CMD_SPARE_A, 6'sd5, 32'h1234_5678);
        send_item(CMD_SPARE_B, -6'sd1, 32'hffff_ffff);
    endtask

    // Word extremes, head, tail and wrapped positions, value search and sort.
    task automatic test_edges();
        send_item(CMD_APPEND, 6'sd0, 32'h7fff_ffff);
        send_item(CMD_APPEND, 6'sd0, 32'h8000_0000);
        send_item(CMD_APPEND, 6'sd0, 32'h0000_0000);
        send_item(CMD_APPEND, 6'sd0, 32'hffff_ffff);
        send_item(CMD_INSERT_AT, 6'sd0, 32'sd5);
        send_item(CMD_INSERT_AT, 6'sd16, 32'h1234_5678);
        send_item(CMD_INSERT_AT, -6'sd16, -32'sd7);
        send_item(CMD_INSERT_AT, -6'sd1, 32'ha5a5_a5a5);
        send_item(CMD_READ_AT, 6'sd0, 32'sd0);
        send_item(CMD_READ_AT, 6'sd16, 32'sd0);
        send_item(CMD_READ_AT, -6'sd5, 32'sd0);
        send_item(CMD_READ_AT, -6'sd16, 32'sd0);
        send_item(CMD_REMOVE_AT, -6'sd16, 32'sd0);
        send_item(CMD_REMOVE_AT, 6'sd16, 32'sd0);
        send_item(CMD_REMOVE_AT, 6'sd0, 32'sd0);
        send_item(CMD_REMOVE_VAL, 6'sd0, 32'h8000_0000);
        send_item(CMD_REMOVE_VAL, 6'sd0, 32'sd99);
        send_item(CMD_SORT, 6'sd0, 32'sd0);
        send_item(CMD_READ_AT, 6'sd0, 32'sd0);
        send_item(CMD_READ_AT, 6'sd15, 32'sd0);
    endtask

    // Random commands; the mix drifts between filling and draining the list so
    // that both the full and the empty cases come up again and again.
    task automatic test_random_mix(input int n_items, input int idle_pct,
                                   input int stall_pct);
        bit                       grow;
        int                       sel;
        int                       pv;
        logic [CMD_W-1:0]         cmd;
        logic signed [WORD_W-1:0] word;
        grow           = 1'b1;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int n = 0; n < n_items; n++) begin
            if (model_count >= LIST_CAP || (model_count > 0 && $urandom_range(0, 99) < 4)) begin
                grow = 1'b0;
            end
            if (model_count == 0 || $urandom_range(0, 99) < 4) begin
                grow = 1'b1;
            end
            sel = $urandom_range(0, 99);
            if (sel < 2) begin
                cmd = $urandom_range(0, 1) ? CMD_SPARE_A : CMD_SPARE_B;
            end else if (grow) begin
                cmd = (sel < 35) ? CMD_APPEND :
                      (sel < 60) ? CMD_INSERT_AT :
                      (sel < 70) ? CMD_REMOVE_AT :
                      (sel < 78) ? CMD_REMOVE_VAL :
                      (sel < 93) ? CMD_READ_AT : CMD_SORT;
            end else begin
                cmd = (sel < 12) ? CMD_APPEND :
                      (sel < 22) ? CMD_INSERT_AT :
                      (sel < 52) ? CMD_REMOVE_AT :
                      (sel < 77) ? CMD_REMOVE_VAL :
                      (sel < 92) ? CMD_READ_AT : CMD_SORT;
            end
            // Value removal mostly looks for a word that is in the list.
            if (cmd == CMD_REMOVE_VAL && model_count > 0 && $urandom_range(0, 9) < 7) begin
                word = model_words[$urandom_range(0, model_count - 1)];
            end else begin
                word = pick_word();
            end
            pv = $urandom_range(0, 32);
            send_item(cmd, POS_W'(pv - 16), word);
        end
    endtask

    // The receiver holds off for a long stretch while beats keep coming, so the
    // block backs up and stalls its input.
    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_req       = 1'b1;
        for (int n = 0; n < 40; n++) begin
            send_item(($urandom_range(0, 2) == 0) ? CMD_READ_AT : CMD_APPEND,
                      POS_W'(int'($urandom_range(0, 32)) - 16), pick_word());
        end
    endtask

    // Stimulus sequence.
    initial begin
        int waited;
        i_rst_n        = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tuser   = '0;
        err_count      = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_req       = 1'b0;
        model_count    = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_list();
        test_edges();
        test_random_mix(170, 0, 0);
        test_random_mix(170, 47, 0);
        test_random_mix(170, 0, 47);
        test_random_mix(170, 9, 9);
        test_backpressure();
        s_axis_tvalid <= 1'b0;

        // Drain the outstanding results, then allow for a late extra beat.
        waited = 0;
        while (pending_results.size() != 0 && waited < 20000) begin
            @(posedge i_clk);
            waited++;
        end
        if (pending_results.size() != 0) begin
            err_count++;
            $display("%0t: %0d results never arrived", $time, pending_results.size());
        end
        repeat (64) @(posedge i_clk);

        if (err_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
